>>> rtl/tunable_white_dimmer_control_defines.svh
// ---------------------------------------------------------------------------
// Tunable white dimmer control: shared assertion macros
// Concurrent assertion shorthands; each expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef TUNABLE_WHITE_DIMMER_CONTROL_DEFINES_SVH
`define TUNABLE_WHITE_DIMMER_CONTROL_DEFINES_SVH

// same-cycle implication
`define TDC_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tdc_pkg.sv
// ---------------------------------------------------------------------------
// tdc_pkg
// Types and constants shared by the tunable white dimmer control modules.
// ---------------------------------------------------------------------------
`default_nettype none

package tdc_pkg;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_BSTEP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GESTURE_BSTEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_TSTEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GESTURE_TSTEP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL = 3'd6;

	// level and color temperature ranges
	localparam logic [7:0] LVL_MIN   = 8'd1;
	localparam logic [7:0] LVL_MAX   = 8'd255;
	localparam logic [8:0] CT_MIN    = 9'd153;
	localparam logic [8:0] CT_MAX    = 9'd500;
	localparam logic [8:0] CT_SPAN   = 9'd347;
	localparam logic [8:0] CT_RESET  = 9'd326;

	// floor(x / 347) = (x * RECIP_MUL) >> RECIP_SHIFT, exact for x < 2^25
	localparam logic [25:0] RECIP_MUL   = 26'd49509710;
	localparam int unsigned RECIP_SHIFT = 34;

	typedef enum logic [2:0] {
		CMD_NONE = 3'd0,
		CMD_ON   = 3'd1,
		CMD_OFF  = 3'd2,
		CMD_BUP  = 3'd3,
		CMD_BDN  = 3'd4,
		CMD_TUP  = 3'd5,
		CMD_TDN  = 3'd6
	} cmd_e;

	typedef enum logic [2:0] {
		GEST_NONE    = 3'd0,
		GEST_LEFT    = 3'd1,
		GEST_RIGHT   = 3'd2,
		GEST_DOWN    = 3'd3,
		GEST_FORWARD = 3'd4,
		GEST_CW      = 3'd5,
		GEST_CCW     = 3'd6,
		GEST_OTHER   = 3'd7
	} gesture_e;

	// one millisecond of input events
	typedef struct packed {
		logic        btn_single;
		logic        btn_double;
		logic        btn_release;
		logic        btn_press;
		logic        btn_hold;
		logic [2:0]  gesture;
		logic        remote_state_present;
		logic        remote_state_on;
		logic        remote_bright_present;
		logic [15:0] remote_bright;
		logic        remote_temp_present;
		logic [15:0] remote_temp;
	} item_t;

	// one result word
	typedef struct packed {
		logic [15:0] pwm_cold;
		logic [15:0] pwm_warm;
		logic        pwm_written;
		logic        lamp_on;
		logic [7:0]  level;
		logic [8:0]  temperature;
		logic [2:0]  command;
		logic        report_due;
	} result_t;

	// control decision handed to the duty pipeline
	typedef struct packed {
		logic [7:0] level;
		logic [8:0] temperature;
		logic       lamp_on;
		cmd_e       command;
		logic       written;
		logic       report_due;
	} ctrl_res_t;

endpackage

`default_nettype wire

>>> rtl/tdc_ctrl.sv
// ---------------------------------------------------------------------------
// tdc_ctrl
// Configuration registers, lamp state and per-item event decoding.
// Consumes one item per cycle unless stalled; registers decision in stage 2.
// ---------------------------------------------------------------------------
`default_nettype none
`include "tunable_white_dimmer_control_defines.svh"

module tdc_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tdc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          up_valid,
	output logic                               up_ready,
	input  wire tdc_pkg::item_t                up_item,
	output logic                               dn_valid,
	input  wire logic                          dn_ready,
	output tdc_pkg::ctrl_res_t                 dn_res
);
	import tdc_pkg::*;

	typedef struct packed {
		logic [7:0] lvl;
		logic [8:0] ct;
		cmd_e       cmd;
	} adj_t;

	// saturating step of level or temperature, depending on mode
	function automatic adj_t adjust(input logic cm, input logic up,
			input logic [7:0] lvl, input logic [8:0] ct,
			input logic [7:0] bstep, input logic [8:0] tstep);
		adj_t       a;
		logic [8:0] lsum;
		logic [9:0] tsum;
		logic [9:0] tfloor;
		a.lvl  = lvl;
		a.ct   = ct;
		a.cmd  = CMD_NONE;
		lsum   = {1'b0, lvl} + {1'b0, bstep};
		tsum   = {1'b0, ct} + {1'b0, tstep};
		tfloor = {1'b0, CT_MIN} + {1'b0, tstep};
		if (cm) begin
			if (up) begin
				a.ct  = (tsum > {1'b0, CT_MAX}) ? CT_MAX : tsum[8:0];
				a.cmd = CMD_TUP;
			end else begin
				a.ct  = ({1'b0, ct} < tfloor) ? CT_MIN : ct - tstep;
				a.cmd = CMD_TDN;
			end
		end else begin
			if (up) begin
				a.lvl = (lsum > {1'b0, LVL_MAX}) ? LVL_MAX : lsum[7:0];
				a.cmd = CMD_BUP;
			end else begin
				a.lvl = (lvl <= bstep) ? LVL_MIN : lvl - bstep;
				a.cmd = CMD_BDN;
			end
		end
		return a;
	endfunction

	// configuration
	logic        color_en_q;
	logic [7:0]  btn_bstep_q;
	logic [7:0]  gst_bstep_q;
	logic [8:0]  btn_tstep_q;
	logic [8:0]  gst_tstep_q;
	logic [9:0]  rep_int_q;
	logic [15:0] rpt_int_q;

	// lamp state
	logic [7:0]  lvl_q;
	logic [8:0]  ct_q;
	logic        pwr_q;
	logic        cmode_q;
	logic        step_up_q;
	logic        hold_q;
	logic [9:0]  rep_q;
	logic [15:0] rpt_q;

	// stage 2
	logic        valid_s2;
	ctrl_res_t   res_s2;

	// next-state values
	logic [7:0]  lvl_n;
	logic [8:0]  ct_n;
	logic        pwr_n;
	logic        cmode_n;
	logic        step_up_n;
	logic        hold_n;
	logic [9:0]  rep_n;
	logic [15:0] rpt_n;
	cmd_e        cmd_n;
	logic        chg;
	logic        wr;
	logic        due;
	adj_t        adj;

	logic        fire;

	assign up_ready = !valid_s2 || dn_ready;
	assign fire     = up_valid && up_ready;
	assign dn_valid = valid_s2;
	assign dn_res   = res_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_en_q  <= 1'b0;
			btn_bstep_q <= 8'd5;
			gst_bstep_q <= 8'd50;
			btn_tstep_q <= 9'd1;
			gst_tstep_q <= 9'd20;
			rep_int_q   <= 10'd20;
			rpt_int_q   <= 16'd60000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLOR_ENABLE:    color_en_q  <= cfg_data[0];
				CFG_BUTTON_BSTEP:    btn_bstep_q <= cfg_data[7:0];
				CFG_GESTURE_BSTEP:   gst_bstep_q <= cfg_data[7:0];
				CFG_BUTTON_TSTEP:    btn_tstep_q <= cfg_data[8:0];
				CFG_GESTURE_TSTEP:   gst_tstep_q <= cfg_data[8:0];
				CFG_REPEAT_INTERVAL: rep_int_q   <= cfg_data[9:0];
				CFG_REPORT_INTERVAL: rpt_int_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// event decoding for the item in stage 1
	always_comb begin
		lvl_n     = lvl_q;
		ct_n      = ct_q;
		pwr_n     = pwr_q;
		cmode_n   = cmode_q;
		step_up_n = step_up_q;
		hold_n    = hold_q;
		cmd_n     = CMD_NONE;
		chg       = 1'b0;
		wr        = 1'b0;
		adj       = '0;

		// elapsed counters, saturating
		rep_n = (rep_q != '1) ? rep_q + 10'd1 : rep_q;
		rpt_n = (rpt_q != '1) ? rpt_q + 16'd1 : rpt_q;

		// button
		if (up_item.btn_single) begin
			cmd_n  = pwr_q ? CMD_OFF : CMD_ON;
			chg    = 1'b1;
			hold_n = 1'b0;
		end
		if (up_item.btn_double) begin
			if (color_en_q) begin
				if (!pwr_q) begin
					cmd_n = CMD_ON;
				end
				cmode_n = !cmode_n;
			end else begin
				cmode_n = 1'b0;
			end
			chg    = 1'b1;
			hold_n = 1'b0;
		end
		// a release while off skips release, press and hold handling
		if (!(up_item.btn_release && !pwr_q)) begin
			if (up_item.btn_release) begin
				step_up_n = !step_up_n;
				if (hold_n) begin
					hold_n = 1'b0;
					chg    = 1'b1;
				end
			end
			if (up_item.btn_press) begin
				rep_n  = '0;
				hold_n = 1'b1;
			end
			if (up_item.btn_hold && pwr_q && (rep_n > rep_int_q)) begin
				rep_n  = '0;
				adj    = adjust(cmode_n, step_up_n, lvl_n, ct_n, btn_bstep_q, btn_tstep_q);
				lvl_n  = adj.lvl;
				ct_n   = adj.ct;
				cmd_n  = adj.cmd;
				hold_n = 1'b1;
				chg    = 1'b1;
			end
		end

		// gesture
		case (gesture_e'(up_item.gesture))
			GEST_LEFT: begin
				if (!pwr_q) begin
					chg   = 1'b1;
					cmd_n = CMD_ON;
				end
			end
			GEST_RIGHT: begin
				if (pwr_q) begin
					chg   = 1'b1;
					cmd_n = CMD_OFF;
				end
			end
			GEST_DOWN, GEST_FORWARD: begin
				cmode_n = color_en_q ? !cmode_n : 1'b0;
			end
			GEST_CW, GEST_CCW: begin
				adj   = adjust(cmode_n, gesture_e'(up_item.gesture) == GEST_CW,
					lvl_n, ct_n, gst_bstep_q, gst_tstep_q);
				lvl_n = adj.lvl;
				ct_n  = adj.ct;
				cmd_n = adj.cmd;
				chg   = 1'b1;
			end
			default: ;
		endcase

		// remote command, values clamped to range
		if (up_item.remote_state_present) begin
			cmd_n = up_item.remote_state_on ? CMD_ON : CMD_OFF;
			chg   = 1'b1;
		end
		if (up_item.remote_bright_present) begin
			if (up_item.remote_bright == 16'd0) begin
				lvl_n = LVL_MIN;
			end else if (up_item.remote_bright[15:8] != 8'd0) begin
				lvl_n = LVL_MAX;
			end else begin
				lvl_n = up_item.remote_bright[7:0];
			end
			chg = 1'b1;
		end
		if (up_item.remote_temp_present && color_en_q) begin
			if (up_item.remote_temp < 16'(CT_MIN)) begin
				ct_n = CT_MIN;
			end else if (up_item.remote_temp > 16'(CT_MAX)) begin
				ct_n = CT_MAX;
			end else begin
				ct_n = up_item.remote_temp[8:0];
			end
			chg = 1'b1;
		end

		// apply command
		if (chg) begin
			case (cmd_n)
				CMD_ON: begin
					pwr_n   = 1'b1;
					cmode_n = 1'b0;
					wr      = 1'b1;
				end
				CMD_OFF: begin
					pwr_n = 1'b0;
					wr    = 1'b1;
				end
				CMD_NONE: wr = 1'b0;
				default:  wr = 1'b1;
			endcase
		end

		// status report
		due = (chg || (rpt_n > rpt_int_q)) && !hold_n;
		if (due) begin
			rpt_n = '0;
		end
	end

	// lamp state; a color_enable write of zero leaves color mode if no item fires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q     <= LVL_MAX;
			ct_q      <= CT_RESET;
			pwr_q     <= 1'b0;
			cmode_q   <= 1'b0;
			step_up_q <= 1'b1;
			hold_q    <= 1'b0;
			rep_q     <= '0;
			rpt_q     <= '1;
		end else if (fire) begin
			lvl_q     <= lvl_n;
			ct_q      <= ct_n;
			pwr_q     <= pwr_n;
			cmode_q   <= cmode_n;
			step_up_q <= step_up_n;
			hold_q    <= hold_n;
			rep_q     <= rep_n;
			rpt_q     <= rpt_n;
		end else if (cfg_we && (cfg_index == CFG_COLOR_ENABLE) && !cfg_data[0]) begin
			cmode_q <= 1'b0;
		end
	end

	// stage 2 handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2.level       <= lvl_n;
			res_s2.temperature <= ct_n;
			res_s2.lamp_on     <= pwr_n;
			res_s2.command     <= cmd_n;
			res_s2.written     <= wr;
			res_s2.report_due  <= due;
		end
	end

	`TDC_ASSERT(a_state_in_range, 1'b1, (lvl_q != 8'd0) && (ct_q >= CT_MIN) && (ct_q <= CT_MAX), "level or temperature left range")
	`TDC_ASSERT_NEXT(a_due_not_in_hold, fire, !(res_s2.report_due && hold_q), "report flagged during hold cycle")
	`TDC_ASSERT(a_off_cmd_lamp, valid_s2 && res_s2.written && (res_s2.command == CMD_OFF), !res_s2.lamp_on, "off command left lamp on")
	`TDC_ASSERT(a_on_cmd_lamp, valid_s2 && res_s2.written && (res_s2.command == CMD_ON), res_s2.lamp_on, "on command left lamp off")

endmodule

`default_nettype wire

>>> rtl/tdc_duty.sv
// ---------------------------------------------------------------------------
// tdc_duty
// PWM duty pipeline: total*(ct-153), reciprocal multiply for /347,
// rounding fixup and the registered result word.
// ---------------------------------------------------------------------------
`default_nettype none
`include "tunable_white_dimmer_control_defines.svh"

module tdc_duty (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               up_valid,
	output logic                    up_ready,
	input  wire tdc_pkg::ctrl_res_t up_res,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output tdc_pkg::result_t        result
);
	import tdc_pkg::*;

	// stage 3: product total * (ct - 153)
	logic        valid_s3;
	ctrl_res_t   meta_s3;
	logic [15:0] total_s3;
	logic [24:0] num_s3;

	// stage 4: reciprocal product
	logic        valid_s4;
	ctrl_res_t   meta_s4;
	logic [15:0] total_s4;
	logic [24:0] num_s4;
	logic [50:0] prod_s4;

	// stage 5: result register and duty state
	logic        valid_s5;
	result_t     res_s5;
	logic [15:0] cold_q;
	logic [15:0] warm_q;

	logic        rdy_s3;
	logic        rdy_s4;
	logic        rdy_s5;

	logic [15:0] total_c;
	logic [8:0]  span_c;
	logic [15:0] quot;
	logic [24:0] back;
	logic [15:0] ceil_q;
	logic [15:0] cold_c;
	logic [15:0] cold_n;
	logic [15:0] warm_n;

	assign rdy_s5   = !valid_s5 || result_ready;
	assign rdy_s4   = !valid_s4 || rdy_s5;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign up_ready = rdy_s3;

	assign result_valid = valid_s5;
	assign result       = res_s5;

	// 257 * b is b repeated in both bytes
	assign total_c = {up_res.level, up_res.level};
	assign span_c  = up_res.temperature - CT_MIN;

	// floor and ceiling of num / 347
	assign quot   = prod_s4[RECIP_SHIFT +: 16];
	assign back   = 25'(quot) * 25'(CT_SPAN);
	assign ceil_q = quot + 16'(back != num_s4);
	assign cold_c = total_s4 - ceil_q;

	// duty update: off clears, other written commands recompute
	always_comb begin
		cold_n = cold_q;
		warm_n = warm_q;
		if (meta_s4.written) begin
			if (meta_s4.command == CMD_OFF) begin
				cold_n = '0;
				warm_n = '0;
			end else begin
				cold_n = cold_c;
				warm_n = quot;
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				valid_s3 <= up_valid;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// duty state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cold_q <= '0;
			warm_q <= '0;
		end else if (valid_s4 && rdy_s5) begin
			cold_q <= cold_n;
			warm_q <= warm_n;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (up_valid && rdy_s3) begin
			meta_s3  <= up_res;
			total_s3 <= total_c;
			num_s3   <= 25'(total_c) * 25'(span_c);
		end
		if (valid_s3 && rdy_s4) begin
			meta_s4  <= meta_s3;
			total_s4 <= total_s3;
			num_s4   <= num_s3;
			prod_s4  <= 51'(num_s3) * 51'(RECIP_MUL);
		end
		if (valid_s4 && rdy_s5) begin
			res_s5.pwm_cold    <= cold_n;
			res_s5.pwm_warm    <= warm_n;
			res_s5.pwm_written <= meta_s4.written;
			res_s5.lamp_on     <= meta_s4.lamp_on;
			res_s5.level       <= meta_s4.level;
			res_s5.temperature <= meta_s4.temperature;
			res_s5.command     <= meta_s4.command;
			res_s5.report_due  <= meta_s4.report_due;
		end
	end

	`TDC_ASSERT(a_off_zero, result_valid && result.pwm_written && (result.command == CMD_OFF), (result.pwm_cold == 16'd0) && (result.pwm_warm == 16'd0), "off did not clear duties")
	`TDC_ASSERT(a_duty_sum, result_valid && result.pwm_written && (result.command != CMD_OFF), ({1'b0, result.pwm_cold} + {1'b0, result.pwm_warm}) <= {1'b0, result.level, result.level}, "duty sum exceeds full scale")

endmodule

`default_nettype wire

>>> rtl/tunable_white_dimmer_control.sv
// ---------------------------------------------------------------------------
// tunable_white_dimmer_control
// Tunable white dimmer: button, gesture and remote handling with PWM duties.
// ---------------------------------------------------------------------------
// Usage:
//   item/item_valid/item_ready carry one millisecond of decoded events;
//   result/result_valid/result_ready return exactly one word per item.
//   cfg_we/cfg_index/cfg_data write a register with no handshake;
//   write only while no item is in flight.
// Pipeline: item accept to result valid passes the input register,
//   control stage, two multiply stages for the duty division by 347
//   and result register.
// Throughput: one item per cycle while the receiver takes results; lamp
//   state updates in the control stage, so the state loop sets the rate.
// Reset: arst_n clears the pipeline and restores lamp state (off, level
//   255, temperature 326) and register defaults; the report timer starts
//   saturated, so a report is due on the first item outside a hold cycle
//   unless the report interval is set to its maximum.
// Stall: each stage holds while the one after it is full, so a stalled
//   receiver backs up the pipeline; items keep entering until every stage
//   is occupied, and nothing is dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module tunable_white_dimmer_control (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tdc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire tdc_pkg::item_t                item,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output tdc_pkg::result_t                   result
);
	import tdc_pkg::*;

	// stage 1: input register
	logic      valid_s1;
	item_t     item_s1;
	logic      ctrl_ready;

	logic      ctrl_valid;
	logic      duty_ready;
	ctrl_res_t ctrl_res;

	assign item_ready = !valid_s1 || ctrl_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	tdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.up_valid  (valid_s1),
		.up_ready  (ctrl_ready),
		.up_item   (item_s1),
		.dn_valid  (ctrl_valid),
		.dn_ready  (duty_ready),
		.dn_res    (ctrl_res)
	);

	tdc_duty u_duty (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (ctrl_valid),
		.up_ready     (duty_ready),
		.up_res       (ctrl_res),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
